// ===== sv/ttd_pkg.sv =====
// ----------------------------------------------------------------------------
// ttd_pkg: shared types and color helpers for the texel decoder
// Format and register codes, channel opcodes, and the channel-widening
// functions used to expand packed texel colors to ARGB8888.
// ----------------------------------------------------------------------------
package ttd_pkg;

  typedef enum logic [2:0] {
    FMT_RGBA32   = 3'd0,
    FMT_RGBA4444 = 3'd1,
    FMT_INDEXED4 = 3'd2,
    FMT_INDEXED8 = 3'd3,
    FMT_RGB5A3   = 3'd4
  } fmt_e_t;

  typedef enum logic [2:0] {
    CFG_FORMAT  = 3'd0,
    CFG_WIDTH   = 3'd1,
    CFG_HEIGHT  = 3'd2,
    CFG_ENTRIES = 3'd3
  } cfg_idx_t;

  typedef enum logic {
    OP_PALETTE = 1'b0,
    OP_TEXEL   = 1'b1
  } op_t;

  // last texel slot of a 4x4 tile
  localparam logic [3:0] TILE_LAST = 4'd15;

  typedef logic [31:0][7:0] lut5_t;
  typedef logic [7:0][7:0]  lut3_t;

  // rounded 5-bit to 8-bit expansion, built at elaboration
  function automatic lut5_t build_w5();
    lut5_t t;
    for (int i = 0; i < 32; i++) begin
      t[i] = 8'((i * 255 + 15) / 31);
    end
    return t;
  endfunction

  // rounded 3-bit to 8-bit expansion, built at elaboration
  function automatic lut3_t build_w3();
    lut3_t t;
    for (int i = 0; i < 8; i++) begin
      t[i] = 8'((i * 255 + 3) / 7);
    end
    return t;
  endfunction

  localparam lut5_t W5_LUT = build_w5();
  localparam lut3_t W3_LUT = build_w3();

  function automatic logic [7:0] widen4(logic [3:0] v);
    return {v, v};
  endfunction

  function automatic logic [7:0] widen5(logic [4:0] v);
    return W5_LUT[v];
  endfunction

  function automatic logic [7:0] widen3(logic [2:0] v);
    return W3_LUT[v];
  endfunction

  function automatic logic [31:0] pack_argb(logic [7:0] r, logic [7:0] g,
                                            logic [7:0] b, logic [7:0] a);
    return {a, r, g, b};
  endfunction

  function automatic logic [31:0] dec_rgba4444(logic [15:0] p);
    return pack_argb(widen4(p[3:0]), widen4(p[7:4]), widen4(p[11:8]),
                     widen4(p[15:12]));
  endfunction

  function automatic logic [31:0] dec_rgb5a3(logic [15:0] p);
    logic [31:0] c;
    if (p[15]) begin
      c = pack_argb(widen5(p[14:10]), widen5(p[9:5]), widen5(p[4:0]), 8'hFF);
    end else begin
      c = pack_argb(widen4(p[11:8]), widen4(p[7:4]), widen4(p[3:0]),
                    widen3(p[14:12]));
    end
    return c;
  endfunction

endpackage

// ===== sv/ttd_in_if.sv =====
// ----------------------------------------------------------------------------
// ttd_in_if: input channel of the texel decoder
// Valid/ready channel carrying one palette write or one texel payload word.
// ----------------------------------------------------------------------------
interface ttd_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  palette_slot;
  logic [31:0] payload;

  modport source (output valid, output operation, output palette_slot,
                  output payload, input ready);
  modport sink   (input valid, input operation, input palette_slot,
                  input payload, output ready);
endinterface

// ===== sv/ttd_out_if.sv =====
// ----------------------------------------------------------------------------
// ttd_out_if: result channel of the texel decoder
// Valid/ready channel carrying one decoded pixel with its position.
// ----------------------------------------------------------------------------
interface ttd_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  pixel_x;
  logic [9:0]  pixel_y;
  logic [31:0] argb;
  logic        bad_index;
  logic        last_in_item;

  modport source (output valid, output pixel_x, output pixel_y, output argb,
                  output bad_index, output last_in_item, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input argb,
                  input bad_index, input last_in_item, output ready);
endinterface

// ===== sv/texture_texel_decoder.sv =====
// ----------------------------------------------------------------------------
// texture_texel_decoder: texture payload to ARGB8888 pixel decoder
// Decodes rgba32, rgba4444, indexed4, indexed8 and 4x4-tiled rgb5a3 texel
// words into pixels tagged with column and row; palette filled in-band.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake          payload
//  --------  ---------  -----------------  ---------------------------------
//  in_ch     sink       valid/ready        operation, palette_slot, payload
//  out_ch    source     valid/ready        pixel_x, pixel_y, argb,
//                                          bad_index, last_in_item
//  cfg_*     sink       cfg_we (no stall)  cfg_index, cfg_wdata
//
//  Flow: an input transaction is taken every cycle while the decode register
//  has room, giving 0, 1 or 2 pixels; the output register moves one pixel per
//  cycle while out_ch.ready is high, so an indexed4 word holds off the next
//  until its second pixel leaves. Path to out_ch: decode reg, then output reg.
//  Reset: synchronous, active low; clears position counters, config and
//  valid flags. The palette is not cleared: entries read before written are
//  undefined.
//  Stalls: out_ch.ready low holds the output register; the decode register
//  then fills and in_ch.ready drops until that pixel moves on.
//
module texture_texel_decoder
  import ttd_pkg::*;
#(
  parameter int MAX_SIDE      = 1024,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [10:0]  cfg_wdata,
  ttd_in_if.sink       in_ch,
  ttd_out_if.source    out_ch
);

  // Counter and index widths
  localparam int SIDE_W = $clog2(MAX_SIDE);
  localparam int DIM_W  = SIDE_W + 1;
  localparam int BLK_N  = (MAX_SIDE + 3) / 4;
  localparam int BLK_W  = (BLK_N > 1) ? $clog2(BLK_N) : 1;
  localparam int IDX_W  = $clog2(PALETTE_DEPTH);

  typedef struct packed {
    logic [SIDE_W-1:0] col;
    logic [SIDE_W-1:0] row;
    logic              wrap;
  } lpos_t;

  // Decode register contents: up to two pixels of one transaction
  typedef struct packed {
    logic        two;
    logic        pal;
    logic        bad0;
    logic        bad1;
    logic [9:0]  x0;
    logic [9:0]  y0;
    logic [9:0]  x1;
    logic [9:0]  y1;
    logic [31:0] argb;
  } dec_t;

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  function automatic logic [DIM_W-1:0] clamp_side(logic [10:0] v);
    logic [31:0] t;
    t = 32'(v);
    if (t == 32'd0) begin
      t = 32'd1;
    end else if (t > 32'(MAX_SIDE)) begin
      t = 32'(MAX_SIDE);
    end
    return t[DIM_W-1:0];
  endfunction

  function automatic logic [9:0] to10(logic [31:0] v);
    return v[9:0];
  endfunction

  // Step one pixel along a raster; wrap flags the end of the image
  function automatic lpos_t advance(lpos_t p, logic [DIM_W-1:0] w,
                                    logic [DIM_W-1:0] h);
    lpos_t q;
    q      = p;
    q.wrap = 1'b0;
    if ({1'b0, p.col} + DIM_W'(1) >= w) begin
      q.col = '0;
      if ({1'b0, p.row} + DIM_W'(1) >= h) begin
        q.row  = '0;
        q.wrap = 1'b1;
      end else begin
        q.row = p.row + SIDE_W'(1);
      end
    end else begin
      q.col = p.col + SIDE_W'(1);
    end
    return q;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [2:0]  fmt_r;
  logic [10:0] width_r;
  logic [10:0] height_r;
  logic [8:0]  entries_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r     <= FMT_RGBA32;
      width_r   <= 11'd1;
      height_r  <= 11'd1;
      entries_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FORMAT:  fmt_r     <= cfg_wdata[2:0];
        CFG_WIDTH:   width_r   <= cfg_wdata;
        CFG_HEIGHT:  height_r  <= cfg_wdata;
        CFG_ENTRIES: entries_r <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0] w_c;
  logic [DIM_W-1:0] h_c;
  logic [DIM_W:0]   bw_c;
  logic [DIM_W:0]   bh_c;
  logic [8:0]       n_eff;

  assign w_c   = clamp_side(width_r);
  assign h_c   = clamp_side(height_r);
  assign bw_c  = ({1'b0, w_c} + (DIM_W + 1)'(3)) >> 2;   // tiles across
  assign bh_c  = ({1'b0, h_c} + (DIM_W + 1)'(3)) >> 2;   // tiles down
  assign n_eff = (entries_r > 9'(PALETTE_DEPTH)) ? 9'(PALETTE_DEPTH) : entries_r;

  // --------------------------------------------------------------------------
  // Handshake and stage control
  // --------------------------------------------------------------------------
  logic       dec_valid_r;
  logic       dec_ptr_r;      // which of the two pixels goes out next
  dec_t       dec_r;
  logic       out_valid_r;
  logic       out_load;
  logic       dec_last;
  logic       in_fire;
  logic       texel_fire;

  assign dec_last    = !dec_r.two || dec_ptr_r;
  assign out_load    = dec_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !dec_valid_r || (out_load && dec_last);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign texel_fire  = in_fire && (in_ch.operation == OP_TEXEL);

  // --------------------------------------------------------------------------
  // Decode of the accepted transaction
  // --------------------------------------------------------------------------
  logic [SIDE_W-1:0] col_r, col_nxt;
  logic [SIDE_W-1:0] row_r, row_nxt;
  logic [BLK_W-1:0]  bcol_r, bcol_nxt;
  logic [BLK_W-1:0]  brow_r, brow_nxt;
  logic [3:0]        inner_r, inner_nxt;

  logic [7:0]        b0;
  logic [15:0]       half;
  lpos_t             pos0, adv1, adv2;
  logic [BLK_W+1:0]  tile_x, tile_y;
  logic [1:0]        n_new;
  dec_t              dec_nxt;
  logic [7:0]        idx0, idx1;

  assign b0   = in_ch.payload[7:0];
  assign half = in_ch.payload[15:0];
  assign pos0 = '{col: col_r, row: row_r, wrap: 1'b0};
  assign adv1 = advance(pos0, w_c, h_c);
  assign adv2 = advance(adv1, w_c, h_c);

  assign tile_x = {bcol_r, inner_r[1:0]};
  assign tile_y = {brow_r, inner_r[3:2]};

  assign idx0 = (fmt_r == FMT_INDEXED4) ? {4'd0, b0[3:0]} : b0;
  assign idx1 = {4'd0, b0[7:4]};

  always_comb begin
    n_new     = 2'd0;
    dec_nxt   = '0;
    col_nxt   = col_r;
    row_nxt   = row_r;
    bcol_nxt  = bcol_r;
    brow_nxt  = brow_r;
    inner_nxt = inner_r;
    dec_nxt.x0 = to10(32'(col_r));
    dec_nxt.y0 = to10(32'(row_r));
    dec_nxt.x1 = to10(32'(adv1.col));
    dec_nxt.y1 = to10(32'(adv1.row));
    dec_nxt.bad0 = {1'b0, idx0} >= n_eff;
    dec_nxt.bad1 = {1'b0, idx1} >= n_eff;
    case (fmt_r)
      FMT_RGBA32: begin
        n_new        = 2'd1;
        dec_nxt.argb = pack_argb(in_ch.payload[7:0], in_ch.payload[15:8],
                                 in_ch.payload[23:16], in_ch.payload[31:24]);
        dec_nxt.bad0 = 1'b0;
        col_nxt      = adv1.col;
        row_nxt      = adv1.row;
      end
      FMT_RGBA4444: begin
        n_new        = 2'd1;
        dec_nxt.argb = dec_rgba4444(half);
        dec_nxt.bad0 = 1'b0;
        col_nxt      = adv1.col;
        row_nxt      = adv1.row;
      end
      FMT_INDEXED4: begin
        // high nibble is dropped when the low one ends the image
        dec_nxt.pal = 1'b1;
        if (adv1.wrap) begin
          n_new   = 2'd1;
          col_nxt = adv1.col;
          row_nxt = adv1.row;
        end else begin
          n_new       = 2'd2;
          dec_nxt.two = 1'b1;
          col_nxt     = adv2.col;
          row_nxt     = adv2.row;
        end
      end
      FMT_INDEXED8: begin
        n_new       = 2'd1;
        dec_nxt.pal = 1'b1;
        col_nxt     = adv1.col;
        row_nxt     = adv1.row;
      end
      FMT_RGB5A3: begin
        dec_nxt.x0   = to10(32'(tile_x));
        dec_nxt.y0   = to10(32'(tile_y));
        dec_nxt.argb = dec_rgb5a3(half);
        dec_nxt.bad0 = 1'b0;
        // padding texels advance the tile walk but emit nothing
        if (32'(tile_x) < 32'(w_c) && 32'(tile_y) < 32'(h_c)) begin
          n_new = 2'd1;
        end
        inner_nxt = inner_r + 4'd1;
        if (inner_r == TILE_LAST) begin
          if (32'(bcol_r) + 32'd1 >= 32'(bw_c)) begin
            bcol_nxt = '0;
            if (32'(brow_r) + 32'd1 >= 32'(bh_c)) begin
              brow_nxt = '0;
            end else begin
              brow_nxt = brow_r + BLK_W'(1);
            end
          end else begin
            bcol_nxt = bcol_r + BLK_W'(1);
          end
        end
      end
      default: ;   // unknown format: no pixel, no counter movement
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      bcol_r  <= '0;
      brow_r  <= '0;
      inner_r <= '0;
    end else if (texel_fire) begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      bcol_r  <= bcol_nxt;
      brow_r  <= brow_nxt;
      inner_r <= inner_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Palette: written by palette transactions, read when a texel is taken so
  // the registered read data lines up with the decode register
  // --------------------------------------------------------------------------
  logic        pal_we;
  logic [31:0] pal_rd0;
  logic [31:0] pal_rd1;

  assign pal_we = in_fire && (in_ch.operation == OP_PALETTE)
                  && (32'(in_ch.palette_slot) < 32'(PALETTE_DEPTH));

  ttd_palette #(
    .DEPTH (PALETTE_DEPTH),
    .AW    (IDX_W)
  ) u_palette (
    .clk      (clk),
    .wr_en    (pal_we),
    .wr_addr  (in_ch.palette_slot[IDX_W-1:0]),
    .wr_data  (pack_argb(in_ch.payload[7:0], in_ch.payload[15:8],
                         in_ch.payload[23:16], in_ch.payload[31:24])),
    .rd_en    (texel_fire),
    .rd_addr0 (idx0[IDX_W-1:0]),
    .rd_addr1 (idx1[IDX_W-1:0]),
    .rd_data0 (pal_rd0),
    .rd_data1 (pal_rd1)
  );

  // --------------------------------------------------------------------------
  // Decode register
  // --------------------------------------------------------------------------
  logic dec_valid_nxt;
  logic dec_ptr_nxt;

  always_comb begin
    dec_valid_nxt = dec_valid_r;
    dec_ptr_nxt   = dec_ptr_r;
    if (out_load) begin
      if (dec_last) begin
        dec_valid_nxt = 1'b0;
        dec_ptr_nxt   = 1'b0;
      end else begin
        dec_ptr_nxt = 1'b1;
      end
    end
    if (texel_fire && n_new != 2'd0) begin
      dec_valid_nxt = 1'b1;
      dec_ptr_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_valid_r <= 1'b0;
      dec_ptr_r   <= 1'b0;
    end else begin
      dec_valid_r <= dec_valid_nxt;
      dec_ptr_r   <= dec_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (texel_fire) begin
      dec_r <= dec_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [9:0]  out_x_r;
  logic [9:0]  out_y_r;
  logic [31:0] out_argb_r;
  logic        out_bad_r;
  logic        out_last_r;
  logic        sel_bad;
  logic [31:0] sel_argb;

  assign sel_bad  = dec_ptr_r ? dec_r.bad1 : dec_r.bad0;
  assign sel_argb = !dec_r.pal ? dec_r.argb :
                    sel_bad    ? 32'h0000_0000 :
                    dec_ptr_r  ? pal_rd1 : pal_rd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x_r    <= dec_ptr_r ? dec_r.x1 : dec_r.x0;
      out_y_r    <= dec_ptr_r ? dec_r.y1 : dec_r.y0;
      out_argb_r <= sel_argb;
      out_bad_r  <= dec_r.pal && sel_bad;
      out_last_r <= dec_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel_x      = out_x_r;
  assign out_ch.pixel_y      = out_y_r;
  assign out_ch.argb         = out_argb_r;
  assign out_ch.bad_index    = out_bad_r;
  assign out_ch.last_in_item = out_last_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  // second pixel pointer only ever set on a live two-pixel transaction
  a_ptr_two: assert property (@(posedge clk) disable iff (!rst_n)
    dec_ptr_r |-> (dec_valid_r && dec_r.two))
    else $error("second-pixel pointer set without a two-pixel transaction");

  // a full decode register only takes a new transaction as its last pixel leaves
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && dec_valid_r) |-> (out_load && dec_last))
    else $error("decode register overwritten before drained");

  // a flagged index never carries a color
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bad_r) |-> (out_argb_r == 32'h0000_0000))
    else $error("bad index pixel carries a color");

  // nothing is presented in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !dec_valid_r))
    else $error("valid state survived reset");
`endif

endmodule

// ===== sv/ttd_palette.sv =====
// ----------------------------------------------------------------------------
// ttd_palette: palette memory
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module ttd_palette #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr0,
  input  logic [AW-1:0] rd_addr1,
  output logic [31:0]   rd_data0,
  output logic [31:0]   rd_data1
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata0_r;
  logic [31:0] rdata1_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata0_r <= mem[rd_addr0];
      rdata1_r <= mem[rd_addr1];
    end
  end

  assign rd_data0 = rdata0_r;
  assign rd_data1 = rdata1_r;

endmodule

// ===== sim/tb_texture_texel_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_texture_texel_decoder: self-checking bench for the texel decoder
// A short directed table hits the format extremes, the palette edge cases and
// the reserved format codes. Randomized phases follow, each with a fresh
// register set and bursty valid/ready traffic on both channels. Every pixel
// is checked against a predictor that tracks palette, positions and tiling.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_texture_texel_decoder;
  import ttd_pkg::*;

  // format codes the block must treat as "no output, no counter motion"
  localparam logic [2:0] FMT_RESERVED_A = 3'd5;
  localparam logic [2:0] FMT_RESERVED_B = 3'd6;
  localparam logic [2:0] FMT_RESERVED_C = 3'd7;

  localparam int SETTLE          = 8;     // decode + output register, plus margin
  localparam int STALL_LIMIT     = 4000;  // cycles without any transaction
  localparam int LONG_HOLD       = 300;   // one long receiver hold-off
  localparam int PHASES          = 14;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int HOLD_PHASE      = 3;
  localparam int RESERVED_PHASE  = 10;

  // one expected pixel, in output-port order
  typedef struct packed {
    logic [9:0]  x;
    logic [9:0]  y;
    logic [31:0] argb;
    logic        bad;
    logic        last;
  } px_t;

  // one row of the directed table: a register write or an input transaction,
  // with optional hand-typed colors for the first pixels it produces
  typedef struct {
    bit                is_cfg;
    cfg_idx_t          reg_idx;
    logic [10:0]       reg_val;
    op_t               op;
    logic [7:0]        slot;
    logic [31:0]       data;
    int                n_typed;
    logic [1:0][31:0]  argb_t;
    logic [1:0]        bad_t;
  } step_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [10:0] cfg_wdata;

  ttd_in_if  in_ch ();
  ttd_out_if out_ch ();

  texture_texel_decoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // 2 ns period
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // --------------------------------------------------------------------------
  // Predictor state: registers, palette and both position trackers
  // --------------------------------------------------------------------------
  logic [2:0]  cur_fmt;
  logic [10:0] cur_width;
  logic [10:0] cur_height;
  logic [8:0]  cur_entries;
  logic [31:0] palette [256];
  logic [9:0]  col_pos;
  logic [9:0]  row_pos;
  logic [7:0]  tile_col;
  logic [7:0]  tile_row;
  logic [3:0]  tile_slot;

  px_t       pixel_q [$];     // pixels still owed by the block
  step_row_t steps [$];       // directed table

  int errors;
  int n_in, n_out, n_bad, n_cfg;
  int burst_left, gap;
  bit hold_req, hold_done;

  // width/height register to a usable side length (0 -> 1, cap at 1024)
  function automatic int unsigned side_len(input logic [10:0] v);
    if (v == 11'd0) return 1;
    if (v > 11'd1024) return 1024;
    return int'(v);
  endfunction

  // n-bit channel to 8 bits with rounding; n = 4 reduces to nibble replication
  function automatic logic [7:0] scale_to_8(input int unsigned v, input int nbits);
    int unsigned top;
    top = (1 << nbits) - 1;
    return 8'((v * 255 + top / 2) / top);
  endfunction

  function automatic logic [31:0] palette_read(input logic [7:0] idx, output logic bad);
    int unsigned limit;
    limit = (cur_entries > 9'd256) ? 256 : int'(cur_entries);
    bad = (int'(idx) >= limit);
    return bad ? 32'h0000_0000 : palette[idx];
  endfunction

  // raster step; returns 1 when the image wrapped back to (0,0)
  function automatic bit step_linear();
    int unsigned w, h;
    w = side_len(cur_width);
    h = side_len(cur_height);
    if (int'(col_pos) + 1 >= w) begin
      col_pos = '0;
      if (int'(row_pos) + 1 >= h) begin
        row_pos = '0;
        return 1'b1;
      end
      row_pos = row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
    return 1'b0;
  endfunction

  // Pixels caused by one accepted transaction; updates predictor state.
  function automatic int predict_pixels(input op_t op, input logic [7:0] slot,
                                        input logic [31:0] data, output px_t [1:0] res);
    logic [15:0] half;
    logic [31:0] color;
    logic        bad;
    int          n;
    int unsigned w, h, bw, bh, x, y;
    half = data[15:0];
    n    = 0;
    res  = '0;
    bad  = 1'b0;
    if (op == OP_PALETTE) begin
      // byte0..3 are red, green, blue, alpha
      palette[slot] = {data[31:24], data[7:0], data[15:8], data[23:16]};
      return 0;
    end
    case (cur_fmt)
      FMT_RGBA32: begin
        res[n] = '{x: col_pos, y: row_pos, argb: {data[31:24], data[7:0], data[15:8],
                   data[23:16]}, bad: 1'b0, last: 1'b0};
        n++;
        void'(step_linear());
      end
      FMT_RGBA4444: begin
        color = {scale_to_8(half[15:12], 4), scale_to_8(half[3:0], 4),
                 scale_to_8(half[7:4], 4), scale_to_8(half[11:8], 4)};
        res[n] = '{x: col_pos, y: row_pos, argb: color, bad: 1'b0, last: 1'b0};
        n++;
        void'(step_linear());
      end
      FMT_INDEXED4: begin
        // low nibble first; the high nibble is dropped if the image ends here
        color = palette_read({4'd0, data[3:0]}, bad);
        res[n] = '{x: col_pos, y: row_pos, argb: color, bad: bad, last: 1'b0};
        n++;
        if (!step_linear()) begin
          color = palette_read({4'd0, data[7:4]}, bad);
          res[n] = '{x: col_pos, y: row_pos, argb: color, bad: bad, last: 1'b0};
          n++;
          void'(step_linear());
        end
      end
      FMT_INDEXED8: begin
        color = palette_read(data[7:0], bad);
        res[n] = '{x: col_pos, y: row_pos, argb: color, bad: bad, last: 1'b0};
        n++;
        void'(step_linear());
      end
      FMT_RGB5A3: begin
        w  = side_len(cur_width);
        h  = side_len(cur_height);
        bw = (w + 3) >> 2;
        bh = (h + 3) >> 2;
        x  = 4 * int'(tile_col) + int'(tile_slot[1:0]);
        y  = 4 * int'(tile_row) + int'(tile_slot[3:2]);
        if (half[15]) begin
          color = {8'hFF, scale_to_8(half[14:10], 5), scale_to_8(half[9:5], 5),
                   scale_to_8(half[4:0], 5)};
        end else begin
          color = {scale_to_8(half[14:12], 3), scale_to_8(half[11:8], 4),
                   scale_to_8(half[7:4], 4), scale_to_8(half[3:0], 4)};
        end
        // texels in the padding band of a tile produce nothing
        if (x < w && y < h) begin
          res[n] = '{x: 10'(x), y: 10'(y), argb: color, bad: 1'b0, last: 1'b0};
          n++;
        end
        if (tile_slot == TILE_LAST) begin
          tile_slot = '0;
          if (int'(tile_col) + 1 >= bw) begin
            tile_col = '0;
            if (int'(tile_row) + 1 >= bh) tile_row = '0;
            else tile_row = tile_row + 1'b1;
          end else begin
            tile_col = tile_col + 1'b1;
          end
        end else begin
          tile_slot = tile_slot + 1'b1;
        end
      end
      default: ;  // reserved codes: nothing moves
    endcase
    if (n > 0) res[n-1].last = 1'b1;
    return n;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // register write; the block is idle whenever this is called
  task automatic write_reg(input cfg_idx_t idx, input logic [10:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_FORMAT:  cur_fmt     = val[2:0];
      CFG_WIDTH:   cur_width   = val;
      CFG_HEIGHT:  cur_height  = val;
      CFG_ENTRIES: cur_entries = val[8:0];
      default: ;
    endcase
    n_cfg++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one transaction in the current burst, wait for the handshake,
  // then queue the pixels it is owed.
  task automatic offer(input step_row_t r);
    px_t [1:0] res;
    int        n;
    int        k;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 12);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= r.op;
    in_ch.palette_slot <= r.slot;
    in_ch.payload      <= r.data;
    do @(posedge clk); while (!in_ch.ready);
    n_in++;
    n = predict_pixels(r.op, r.slot, r.data, res);
    for (k = 0; k < n; k++) begin
      if (k < r.n_typed) begin
        res[k].argb = r.argb_t[k];
        res[k].bad  = r.bad_t[k];
      end
      pixel_q.insert(pixel_q.size(), res[k]);
    end
  endtask

  // Stop offering, wait for every owed pixel, then let the decode and output
  // registers settle before touching registers.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pixel_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // directed table builders
  task automatic add_cfg(input cfg_idx_t idx, input logic [10:0] val);
    step_row_t r;
    r         = '{default: '0, reg_idx: CFG_FORMAT, op: OP_TEXEL};
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    steps.insert(steps.size(), r);
  endtask

  task automatic add_item(input op_t op, input logic [7:0] slot, input logic [31:0] data,
                          input int n_typed = 0,
                          input logic [31:0] a0 = '0, input logic b0 = 1'b0,
                          input logic [31:0] a1 = '0, input logic b1 = 1'b0);
    step_row_t r;
    r         = '{default: '0, reg_idx: CFG_FORMAT, op: OP_TEXEL};
    r.op      = op;
    r.slot    = slot;
    r.data    = data;
    r.n_typed = n_typed;
    r.argb_t  = {a1, a0};
    r.bad_t   = {b1, b0};
    steps.insert(steps.size(), r);
  endtask

  function automatic logic [10:0] pick_side();
    case ($urandom_range(0, 9))
      0: return 11'd0;
      1: return 11'd1024;
      2: return 11'd2047;
      3: return 11'd1;
      default: return 11'($urandom_range(1, 13));
    endcase
  endfunction

  function automatic logic [10:0] pick_entries();
    case ($urandom_range(0, 7))
      0: return 11'd0;
      1: return 11'd1;
      2: return 11'd16;
      3: return 11'd255;
      4: return 11'd256;
      5: return 11'd511;
      default: return 11'($urandom_range(0, 300));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: ready follows segments of different stall patterns, with one
  // long hold-off on request so the decode stage backs up into in_ch.ready.
  // --------------------------------------------------------------------------
  initial begin : rx_pattern
    int mode, seg, cyc;
    out_ch.ready <= 1'b0;
    cyc = 0;
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(8, 60);
      repeat (seg) begin
        @(posedge clk);
        cyc++;
        if (hold_req && !hold_done) begin
          out_ch.ready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
          hold_done = 1'b1;
        end else begin
          case (mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= 1'($urandom_range(0, 1));
            2: out_ch.ready <= ($urandom_range(0, 3) == 0);
            default: out_ch.ready <= (cyc % 3 == 0);
          endcase
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: each pixel transaction against the oldest owed pixel
  // --------------------------------------------------------------------------
  px_t head;

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: pixel %0d %s mismatch: expected 0x%0h, actual 0x%0h",
               $time, n_out, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pixel_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel: expected none, actual x=%0d y=%0d argb=0x%0h",
                 $time, out_ch.pixel_x, out_ch.pixel_y, out_ch.argb);
      end else begin
        head = pixel_q.pop_front();
        check_field("pixel_x", 32'(head.x), 32'(out_ch.pixel_x));
        check_field("pixel_y", 32'(head.y), 32'(out_ch.pixel_y));
        check_field("argb", head.argb, out_ch.argb);
        check_field("bad_index", 32'(head.bad), 32'(out_ch.bad_index));
        check_field("last_in_item", 32'(head.last), 32'(out_ch.last_in_item));
      end
      n_out++;
      if (out_ch.bad_index === 1'b1) n_bad++;
    end
  end

  // Watchdog: a stuck handshake or a lost pixel ends the run here.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no transaction for %0d cycles, %0d pixels still owed",
             $time, STALL_LIMIT, pixel_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main
    step_row_t   r;
    int          i, p, n_items;
    logic [2:0]  fmt_code;
    logic [10:0] w_val;
    logic [10:0] h_val;

    // predictor matches the reset state; palette is only read once written
    cur_fmt     = FMT_RGBA32;
    cur_width   = 11'd1;
    cur_height  = 11'd1;
    cur_entries = '0;
    col_pos     = '0;
    row_pos     = '0;
    tile_col    = '0;
    tile_row    = '0;
    tile_slot   = '0;
    errors      = 0;
    n_in        = 0;
    n_out       = 0;
    n_bad       = 0;
    n_cfg       = 0;
    burst_left  = 0;
    gap         = 0;
    hold_req    = 1'b0;
    hold_done   = 1'b0;

    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_FORMAT;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.operation    <= OP_TEXEL;
    in_ch.palette_slot <= '0;
    in_ch.payload      <= '0;

    // Directed table. After reset: rgba32 on a 1x1 image, so every pixel
    // lands on (0,0) and the image wraps each transaction.
    add_item(OP_TEXEL, 8'd0, 32'h0000_0000, 1, 32'h0000_0000);
    add_item(OP_TEXEL, 8'd0, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF);
    add_item(OP_TEXEL, 8'd0, 32'h4433_2211, 1, 32'h4411_2233);
    add_item(OP_PALETTE, 8'd0,   32'h8040_2010);
    add_item(OP_PALETTE, 8'd255, 32'hFFFF_FFFF);
    // rgba4444, zero width clamps to 1, oversized height clamps to 1024
    add_cfg(CFG_FORMAT, 11'(FMT_RGBA4444));
    add_cfg(CFG_WIDTH, 11'd0);
    add_cfg(CFG_HEIGHT, 11'd2047);
    add_item(OP_TEXEL, 8'd0, 32'hABCD_F00F, 1, 32'hFFFF_0000);
    add_item(OP_TEXEL, 8'd0, 32'h0000_1234);
    add_item(OP_TEXEL, 8'd0, 32'h0000_7FFF);
    // tiled rgb5a3 on 2x1: two real texels, then padding
    add_cfg(CFG_FORMAT, 11'(FMT_RGB5A3));
    add_cfg(CFG_WIDTH, 11'd2);
    add_cfg(CFG_HEIGHT, 11'd1);
    add_item(OP_TEXEL, 8'd0, 32'h0000_FFFF, 1, 32'hFFFF_FFFF);
    add_item(OP_TEXEL, 8'd0, 32'h0000_0000, 1, 32'h0000_0000);
    add_item(OP_TEXEL, 8'd0, 32'h0000_1234);
    // indexed8 with the entry count above palette depth
    add_cfg(CFG_FORMAT, 11'(FMT_INDEXED8));
    add_cfg(CFG_ENTRIES, 11'd511);
    add_item(OP_TEXEL, 8'd0, 32'h0000_0000, 1, 32'h8010_2040);
    add_item(OP_TEXEL, 8'd0, 32'h0000_00FF, 1, 32'hFFFF_FFFF);
    // empty palette: every index is flagged
    add_cfg(CFG_ENTRIES, 11'd0);
    add_item(OP_TEXEL, 8'd0, 32'h0000_0000, 1, 32'h0000_0000, 1'b1);
    // indexed4, one entry: low nibble hits, high nibble is flagged
    add_cfg(CFG_FORMAT, 11'(FMT_INDEXED4));
    add_cfg(CFG_ENTRIES, 11'd1);
    add_cfg(CFG_WIDTH, 11'd1024);
    add_item(OP_TEXEL, 8'd0, 32'h0000_0010, 2, 32'h8010_2040, 1'b0, 32'h0000_0000, 1'b1);
    // shrink to 1x1 with the column beyond it: one pixel, high nibble dropped
    add_cfg(CFG_WIDTH, 11'd1);
    add_cfg(CFG_HEIGHT, 11'd1);
    add_item(OP_TEXEL, 8'd0, 32'h0000_00F0, 1, 32'h8010_2040);
    // reserved format codes swallow payload
    add_cfg(CFG_FORMAT, 11'(FMT_RESERVED_A));
    add_item(OP_TEXEL, 8'd0, 32'h1234_5678);
    add_cfg(CFG_FORMAT, 11'(FMT_RESERVED_B));
    add_item(OP_TEXEL, 8'd0, 32'h8765_4321);
    add_cfg(CFG_FORMAT, 11'(FMT_RESERVED_C));
    add_item(OP_TEXEL, 8'd0, 32'hFFFF_FFFF);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < steps.size(); i++) begin
      if (steps[i].is_cfg) begin
        if (i == 0 || !steps[i-1].is_cfg) drain();
        write_reg(steps[i].reg_idx, steps[i].reg_val);
      end else begin
        offer(steps[i]);
      end
    end

    // Fill the whole palette so random indexes never hit an unwritten entry.
    r = '{default: '0, reg_idx: CFG_FORMAT, op: OP_PALETTE};
    for (i = 0; i < 256; i++) begin
      r.slot = 8'(i);
      r.data = $urandom();
      offer(r);
    end

    // Random phases: new registers each phase, counters carry over so that
    // shrinking dimensions catch the position trackers past the new edge.
    for (p = 0; p < PHASES; p++) begin
      drain();
      if (p == RESERVED_PHASE)
        fmt_code = 3'($urandom_range(FMT_RESERVED_A, FMT_RESERVED_C));
      else if (p < RESERVED_PHASE)
        fmt_code = 3'(p % 5);
      else
        fmt_code = 3'($urandom_range(FMT_RGBA32, FMT_RGB5A3));
      w_val = pick_side();
      h_val = pick_side();
      if (p == 0) w_val = 11'd1024;
      if (p == 4) begin
        w_val = 11'd2047;
        h_val = 11'd1024;
      end
      write_reg(CFG_FORMAT, {8'd0, fmt_code});
      write_reg(CFG_WIDTH, w_val);
      write_reg(CFG_HEIGHT, h_val);
      write_reg(CFG_ENTRIES, pick_entries());

      n_items = (p == RESERVED_PHASE) ? 30 : ITEMS_PER_PHASE;
      for (i = 0; i < n_items; i++) begin
        if (p == HOLD_PHASE && i == 5) hold_req = 1'b1;
        r.op   = ($urandom_range(0, 9) == 0) ? OP_PALETTE : OP_TEXEL;
        r.slot = 8'($urandom_range(0, 255));
        r.data = $urandom();
        // keep plenty of indexes under small entry counts
        if ((fmt_code == FMT_INDEXED8 || fmt_code == FMT_INDEXED4) &&
            $urandom_range(0, 1) == 1)
          r.data[7:0] = 8'($urandom_range(0, 20));
        offer(r);
      end
    end

    drain();

    $display("coverage: %0d input transactions, %0d pixels checked, %0d with bad index,",
             n_in, n_out, n_bad);
    $display("coverage: %0d reg writes; all formats and reserved codes, sizes 0..2047, %s",
             n_cfg, "long output stall");
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
sv/ttd_pkg.sv
sv/ttd_in_if.sv
sv/ttd_out_if.sv
sv/ttd_palette.sv
sv/texture_texel_decoder.sv
sim/tb_texture_texel_decoder.sv
